// ===== rtl/rfd_pkg.sv =====
// shared types, constants and register codes for the radio frame deframer
package rfd_pkg;

    localparam int PAYLOAD_LEN = 7;
    localparam int CNT_W       = $clog2(PAYLOAD_LEN + 2);
    localparam int IDX_W       = $clog2(PAYLOAD_LEN);
    localparam logic [7:0] STOP_BYTE = 8'd254;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PITCH_MIN    = 3'd0,
        REG_PITCH_MAX    = 3'd1,
        REG_ROLL_MIN     = 3'd2,
        REG_ROLL_MAX     = 3'd3,
        REG_THROTTLE_OFF = 3'd4,
        REG_THROTTLE_MAX = 3'd5,
        REG_YAW_MIN      = 3'd6,
        REG_YAW_MAX      = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LEN   = 2'd1,
        ST_CKSUM = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    localparam logic signed [15:0] RST_PITCH_MIN    = -16'sd45;
    localparam logic signed [15:0] RST_PITCH_MAX    = 16'sd45;
    localparam logic signed [15:0] RST_ROLL_MIN     = -16'sd45;
    localparam logic signed [15:0] RST_ROLL_MAX     = 16'sd45;
    localparam logic signed [15:0] RST_THROTTLE_OFF = 16'sd1000;
    localparam logic signed [15:0] RST_THROTTLE_MAX = 16'sd1900;
    localparam logic signed [15:0] RST_YAW_MIN      = -16'sd180;
    localparam logic signed [15:0] RST_YAW_MAX      = 16'sd180;

    typedef struct packed {
        logic signed [15:0] pitch_min;
        logic signed [15:0] pitch_max;
        logic signed [15:0] roll_min;
        logic signed [15:0] roll_max;
        logic signed [15:0] throttle_off;
        logic signed [15:0] throttle_max;
        logic signed [15:0] yaw_min;
        logic signed [15:0] yaw_max;
    } t_limits;

    // one closed frame as handed from the collector to the decoder
    typedef struct packed {
        logic                             len_ok;
        logic [PAYLOAD_LEN-1:0][7:0]      bytes;
    } t_frame;

endpackage

// ===== rtl/rfd_front.sv =====
// byte collector: counts data bytes, stores the frame and posts a request per stop byte
module rfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_q_full,
    output logic                o_stall,
    output logic                o_push,
    output rfd_pkg::t_frame     o_frame
);

    logic [rfd_pkg::CNT_W-1:0]                r_count;
    logic [rfd_pkg::CNT_W-1:0]                n_count;
    logic [rfd_pkg::PAYLOAD_LEN-1:0][7:0]     r_bytes;
    logic [rfd_pkg::CNT_W-1:0]                w_base;
    logic                                     w_accept;
    logic                                     w_stop;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_stop   = (i_byte == rfd_pkg::STOP_BYTE);

    // a ninth data byte drops the frame and starts a new one
    assign w_base = (r_count > rfd_pkg::CNT_W'(rfd_pkg::PAYLOAD_LEN)) ?
                    '0 : r_count;

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (w_stop) begin
                n_count = '0;
            end else begin
                n_count = w_base + rfd_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_stop &&
            (w_base < rfd_pkg::CNT_W'(rfd_pkg::PAYLOAD_LEN))) begin
            r_bytes[w_base[rfd_pkg::IDX_W-1:0]] <= i_byte;
        end
    end

    assign o_push         = w_accept && w_stop;
    assign o_frame.len_ok = (r_count == rfd_pkg::CNT_W'(rfd_pkg::PAYLOAD_LEN));
    assign o_frame.bytes  = r_bytes;

endmodule

// ===== rtl/rfd_queue.sv =====
// short frame queue between the collector and the decoder
module rfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rfd_pkg::t_frame     i_frame,
    output logic                o_full,
    output logic                o_valid,
    output rfd_pkg::t_frame     o_frame,
    input  logic                i_pop
);

    rfd_pkg::t_frame                  r_mem [rfd_pkg::QDEPTH];
    logic [rfd_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [rfd_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [rfd_pkg::QCNT_W-1:0]       r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_full  = (r_count == rfd_pkg::QCNT_W'(rfd_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == rfd_pkg::QPTR_W'(rfd_pkg::QDEPTH - 1)) ?
                            '0 : r_wr_ptr + rfd_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == rfd_pkg::QPTR_W'(rfd_pkg::QDEPTH - 1)) ?
                            '0 : r_rd_ptr + rfd_pkg::QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + rfd_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - rfd_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= rfd_pkg::QCNT_W'(rfd_pkg::QDEPTH))
        else $error("frame queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("frame request pushed into a full queue");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - rfd_pkg::QCNT_W'(1)))
        else $error("queue count did not drop after a pop");
`endif

endmodule

// ===== rtl/rfd_back.sv =====
// frame decoder: checksum and field decode, then range check into the output register
module rfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rfd_pkg::t_frame     i_frame,
    output logic                o_pop,
    input  rfd_pkg::t_limits    i_limits,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic [14:0]         o_throttle,
    output logic signed [8:0]   o_pitch,
    output logic signed [8:0]   o_roll,
    output logic signed [15:0]  o_yaw
);

    function automatic logic in_window(input logic signed [16:0] v,
                                       input logic signed [15:0] lo,
                                       input logic signed [15:0] hi);
        logic signed [16:0] lo_x;
        logic signed [16:0] hi_x;
        lo_x = {lo[15], lo};
        hi_x = {hi[15], hi};
        return (v >= lo_x) && (v <= hi_x);
    endfunction

    // decode stage
    logic                       r_s1_valid;
    logic                       r_s1_len_ok;
    logic                       r_s1_cs_ok;
    logic [14:0]                r_s1_thr;
    logic signed [8:0]          r_s1_pitch;
    logic signed [8:0]          r_s1_roll;
    logic signed [15:0]         r_s1_yaw;

    logic                       w_s2_load;
    logic                       w_s1_load;
    logic [7:0]                 w_sum;
    logic [14:0]                w_thr;
    logic signed [17:0]         w_yaw_full;
    logic signed [16:0]         w_thr_x;
    logic signed [16:0]         w_pitch_x;
    logic signed [16:0]         w_roll_x;
    logic signed [16:0]         w_yaw_x;
    logic                       w_all_in;
    rfd_pkg::t_status           w_status;

    assign w_s2_load = !o_valid || !i_stall;
    assign w_s1_load = !r_s1_valid || w_s2_load;
    assign o_pop     = i_q_valid && w_s1_load;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < rfd_pkg::PAYLOAD_LEN - 1; k++) begin
            w_sum = (w_sum + i_frame.bytes[k]) << 1;
        end
    end

    assign w_thr = 15'd1000 + (15'(i_frame.bytes[0]) * 15'd100)
                 + 15'(i_frame.bytes[1]);
    assign w_yaw_full = $signed({1'b0, i_frame.bytes[5]})
                      * ($signed({1'b0, i_frame.bytes[4]}) - 9'sd127);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_len_ok <= i_frame.len_ok;
            r_s1_cs_ok  <= (w_sum == i_frame.bytes[rfd_pkg::PAYLOAD_LEN-1]);
            r_s1_thr    <= w_thr;
            r_s1_pitch  <= $signed({1'b0, i_frame.bytes[2]}) - 9'sd127;
            r_s1_roll   <= $signed({1'b0, i_frame.bytes[3]}) - 9'sd127;
            r_s1_yaw    <= w_yaw_full[15:0];
        end
    end

    // range stage
    assign w_thr_x   = $signed({2'b00, r_s1_thr});
    assign w_pitch_x = {{8{r_s1_pitch[8]}}, r_s1_pitch};
    assign w_roll_x  = {{8{r_s1_roll[8]}}, r_s1_roll};
    assign w_yaw_x   = {r_s1_yaw[15], r_s1_yaw};

    assign w_all_in = in_window(w_pitch_x, i_limits.pitch_min, i_limits.pitch_max)
                   && in_window(w_roll_x, i_limits.roll_min, i_limits.roll_max)
                   && in_window(w_thr_x, i_limits.throttle_off, i_limits.throttle_max)
                   && in_window(w_yaw_x, i_limits.yaw_min, i_limits.yaw_max);

    always_comb begin
        if (!r_s1_len_ok) begin
            w_status = rfd_pkg::ST_LEN;
        end else if (!r_s1_cs_ok) begin
            w_status = rfd_pkg::ST_CKSUM;
        end else if (!w_all_in) begin
            w_status = rfd_pkg::ST_RANGE;
        end else begin
            w_status = rfd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_s2_load) begin
            o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_load && r_s1_valid) begin
            o_status <= w_status;
            // a wrong-length frame reports zero fields
            if (r_s1_len_ok) begin
                o_throttle <= r_s1_thr;
                o_pitch    <= r_s1_pitch;
                o_roll     <= r_s1_roll;
                o_yaw      <= r_s1_yaw;
            end else begin
                o_throttle <= '0;
                o_pitch    <= '0;
                o_roll     <= '0;
                o_yaw      <= '0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_valid && i_stall) |=> r_s1_valid)
        else $error("decode stage lost a frame under output stall");

    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_valid && i_stall) |-> !o_pop)
        else $error("queue popped while decode stage blocked");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rfd_pkg::ST_LEN)) |->
        ((o_throttle == '0) && (o_yaw == '0)))
        else $error("wrong-length result carries non-zero fields");
`endif

endmodule

// ===== rtl/radio_frame_deframer_unit.sv =====
// radio frame deframer: limit registers and wiring of collector, queue and decoder
//
// usage
//   input channel: one link byte per request on i_rx_byte with i_rx_valid;
//   a byte is taken at a clock edge with i_rx_valid high and o_rx_stall low.
//   output channel: one result per stop byte (0xfe) on o_status, o_throttle,
//   o_pitch, o_roll and o_yaw with o_res_valid; taken when i_res_stall is low.
//   limits are written through i_cfg_wr_en / i_cfg_idx / i_cfg_data, one
//   16-bit register per write, only while no frame is in flight; the user
//   must keep to this, the block itself does not enforce it.
// throughput: one byte per cycle while o_rx_stall is low.
// stop byte path: queue write, decode register, range-check output register.
// reset (synchronous, active low): byte count cleared, limits back to their
//   defaults, queue and decode pipeline emptied. stored frame bytes keep
//   whatever they held.
// receiver stall: the output register holds its result, the decode stage
//   and the two-entry queue fill up, and only then o_rx_stall rises; data
//   bytes keep flowing into the collector until that point.
module radio_frame_deframer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rx_valid,
    output logic                                o_rx_stall,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_stall,
    output logic [1:0]                          o_status,
    output logic [14:0]                         o_throttle,
    output logic signed [8:0]                   o_pitch,
    output logic signed [8:0]                   o_roll,
    output logic signed [15:0]                  o_yaw,
    input  logic                                i_cfg_wr_en,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    rfd_pkg::t_limits   r_limits;
    rfd_pkg::t_frame    w_push_frame;
    rfd_pkg::t_frame    w_q_frame;
    logic               w_push;
    logic               w_q_full;
    logic               w_q_valid;
    logic               w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.pitch_min    <= rfd_pkg::RST_PITCH_MIN;
            r_limits.pitch_max    <= rfd_pkg::RST_PITCH_MAX;
            r_limits.roll_min     <= rfd_pkg::RST_ROLL_MIN;
            r_limits.roll_max     <= rfd_pkg::RST_ROLL_MAX;
            r_limits.throttle_off <= rfd_pkg::RST_THROTTLE_OFF;
            r_limits.throttle_max <= rfd_pkg::RST_THROTTLE_MAX;
            r_limits.yaw_min      <= rfd_pkg::RST_YAW_MIN;
            r_limits.yaw_max      <= rfd_pkg::RST_YAW_MAX;
        end else if (i_cfg_wr_en) begin
            case (rfd_pkg::t_reg_idx'(i_cfg_idx))
                rfd_pkg::REG_PITCH_MIN:    r_limits.pitch_min    <= $signed(i_cfg_data);
                rfd_pkg::REG_PITCH_MAX:    r_limits.pitch_max    <= $signed(i_cfg_data);
                rfd_pkg::REG_ROLL_MIN:     r_limits.roll_min     <= $signed(i_cfg_data);
                rfd_pkg::REG_ROLL_MAX:     r_limits.roll_max     <= $signed(i_cfg_data);
                rfd_pkg::REG_THROTTLE_OFF: r_limits.throttle_off <= $signed(i_cfg_data);
                rfd_pkg::REG_THROTTLE_MAX: r_limits.throttle_max <= $signed(i_cfg_data);
                rfd_pkg::REG_YAW_MIN:      r_limits.yaw_min      <= $signed(i_cfg_data);
                rfd_pkg::REG_YAW_MAX:      r_limits.yaw_max      <= $signed(i_cfg_data);
                default:                   r_limits              <= r_limits;
            endcase
        end
    end

    rfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_rx_valid),
        .i_byte   (i_rx_byte),
        .i_q_full (w_q_full),
        .o_stall  (o_rx_stall),
        .o_push   (w_push),
        .o_frame  (w_push_frame)
    );

    rfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_frame (w_q_frame),
        .i_pop   (w_pop)
    );

    rfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_frame    (w_q_frame),
        .o_pop      (w_pop),
        .i_limits   (r_limits),
        .o_valid    (o_res_valid),
        .i_stall    (i_res_stall),
        .o_status   (o_status),
        .o_throttle (o_throttle),
        .o_pitch    (o_pitch),
        .o_roll     (o_roll),
        .o_yaw      (o_yaw)
    );

endmodule
